// ===== sv/sstl_pkg.sv =====
// Shared types and constants for the SMBIOS structure-table string locator.
package sstl_pkg;

	typedef struct packed {
		logic [7:0] table_byte;
		logic       table_start;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  string_slot;
		logic        string_present;
		logic [15:0] string_offset;
		logic        run_last;
	} out_item_t;

	// One closed structure of a wanted type, waiting to be reported.
	typedef struct packed {
		logic             is_sys;
		logic [3:0]       present;
		logic [3:0][15:0] offset;
	} run_t;

	typedef struct packed {
		logic valid;
		run_t run;
	} run_push_t;

	localparam logic [7:0]  TYPE_BIOS           = 8'd0;
	localparam logic [7:0]  TYPE_SYS            = 8'd1;
	localparam logic [7:0]  MIN_FMT_LEN         = 8'd4;
	localparam logic [2:0]  SLOT_SYS_BASE       = 3'd3;
	localparam logic [1:0]  LAST_BIOS_IDX       = 2'd2;
	localparam logic [1:0]  LAST_SYS_IDX        = 2'd3;
	localparam logic [2:0]  STR_FULL            = 3'd4;
	localparam logic [15:0] POS_MAX             = 16'hFFFF;
	localparam logic        CFG_TABLE_LENGTH    = 1'b0;
	localparam logic        CFG_STRUCTURE_LIMIT = 1'b1;

endpackage

// ===== sv/sstl_front.sv =====
// Front end: walks the table byte stream and captures string offsets per structure.
module sstl_front import sstl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	input  logic [15:0] table_length,
	input  logic [15:0] structure_limit,
	input  logic        queue_full,
	output run_push_t   push
);

	localparam logic PH_HEADER  = 1'b0;
	localparam logic PH_STRINGS = 1'b1;

	logic [15:0]      pos_q, start_q, seen_q;
	logic [7:0]       type_q, flen_q;
	logic [2:0]       strnum_q;
	logic             phase_q, prev_zero_q, done_q;
	logic [3:0]       present_q;
	logic [3:0][15:0] off_q;

	logic [15:0]      pos_n, start_n, seen_n;
	logic [7:0]       type_n, flen_n;
	logic [2:0]       strnum_n;
	logic             phase_n, prev_zero_n, done_n;
	logic [3:0]       present_n;
	logic [3:0][15:0] off_n;

	logic [15:0] p, st, seen_e, rel;
	logic [7:0]  type_e, flen_e, b;
	logic [2:0]  strnum_e;
	logic        phase_e, prev_e, done_e, hdr_ok, first, accept, close_run;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign b        = in_data.table_byte;

	always_comb begin
		// a start mark restarts the walk before this byte is taken
		p        = in_data.table_start ? 16'd0 : pos_q;
		st       = in_data.table_start ? 16'd0 : start_q;
		seen_e   = in_data.table_start ? 16'd0 : seen_q;
		type_e   = in_data.table_start ? 8'd0 : type_q;
		flen_e   = in_data.table_start ? 8'd0 : flen_q;
		strnum_e = in_data.table_start ? 3'd0 : strnum_q;
		phase_e  = in_data.table_start ? PH_HEADER : phase_q;
		prev_e   = in_data.table_start ? 1'b0 : prev_zero_q;
		done_e   = in_data.table_start ? 1'b0 : done_q;

		pos_n       = (p < POS_MAX) ? p + 16'd1 : p;
		start_n     = st;
		seen_n      = seen_e;
		type_n      = type_e;
		flen_n      = flen_e;
		strnum_n    = strnum_e;
		phase_n     = phase_e;
		prev_zero_n = prev_e;
		done_n      = done_e;
		present_n   = in_data.table_start ? 4'd0 : present_q;
		off_n       = off_q;
		close_run   = 1'b0;
		hdr_ok      = 1'b1;
		rel         = p - st;
		first       = ({1'b0, p} == {1'b0, st} + {9'd0, flen_e});

		if (!done_e) begin
			if (p >= table_length) begin
				done_n = 1'b1;
			end else if (phase_e == PH_HEADER) begin
				if (rel == 16'd0) begin
					if (seen_e >= structure_limit
						|| ({1'b0, st} + 17'd4) > {1'b0, table_length}) begin
						done_n = 1'b1;
						hdr_ok = 1'b0;
					end else begin
						type_n = b;
					end
				end else if (rel == 16'd1) begin
					flen_n = (b < MIN_FMT_LEN) ? MIN_FMT_LEN : b;
				end
				if (hdr_ok && rel >= 16'd3
					&& ({1'b0, rel} + 17'd1) >= {9'd0, flen_e}) begin
					if (({1'b0, st} + {9'd0, flen_e} + 17'd1) >= {1'b0, table_length}) begin
						done_n = 1'b1;
					end else begin
						present_n   = 4'd0;
						strnum_n    = 3'd0;
						prev_zero_n = 1'b0;
						phase_n     = PH_STRINGS;
					end
				end
			end else begin
				if (!first && prev_e && b == 8'd0) begin
					close_run   = 1'b1;
					seen_n      = seen_e + 16'd1;
					start_n     = p + 16'd1;
					phase_n     = PH_HEADER;
					prev_zero_n = 1'b0;
				end else begin
					if (first || prev_e) begin
						if (b == 8'd0) begin
							strnum_n = STR_FULL;
						end else if (strnum_e < STR_FULL) begin
							present_n[strnum_e[1:0]] = 1'b1;
							off_n[strnum_e[1:0]]     = p;
							strnum_n                 = strnum_e + 3'd1;
						end
					end
					prev_zero_n = (b == 8'd0);
					if (({1'b0, p} + 17'd1) >= {1'b0, table_length}) begin
						done_n = 1'b1;
					end
				end
			end
		end
	end

	assign push.valid       = accept && close_run
		&& (type_e == TYPE_BIOS || type_e == TYPE_SYS);
	assign push.run.is_sys  = (type_e == TYPE_SYS);
	assign push.run.present = present_q;
	assign push.run.offset  = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			start_q     <= '0;
			seen_q      <= '0;
			type_q      <= '0;
			flen_q      <= '0;
			strnum_q    <= '0;
			phase_q     <= PH_HEADER;
			prev_zero_q <= 1'b0;
			done_q      <= 1'b0;
			present_q   <= '0;
		end else if (accept) begin
			pos_q       <= pos_n;
			start_q     <= start_n;
			seen_q      <= seen_n;
			type_q      <= type_n;
			flen_q      <= flen_n;
			strnum_q    <= strnum_n;
			phase_q     <= phase_n;
			prev_zero_q <= prev_zero_n;
			done_q      <= done_n;
			present_q   <= present_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_q <= off_n;
		end
	end

endmodule

// ===== sv/sstl_queue.sv =====
// Short queue of closed structures between the front end and the result emitter.
module sstl_queue import sstl_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  run_push_t push,
	output logic      full,
	output logic      head_valid,
	output run_t      head,
	input  logic      pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/sstl_back.sv =====
// Result emitter: unrolls one queued structure into its string results.
module sstl_back import sstl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  run_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [1:0] idx_q;
	logic       out_valid_q, load, last;
	out_item_t  out_q;

	assign last = (idx_q == (head.is_sys ? LAST_SYS_IDX : LAST_BIOS_IDX));
	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && last;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.string_slot    <= head.is_sys ? SLOT_SYS_BASE + {1'b0, idx_q}
				: {1'b0, idx_q};
			out_q.string_present <= head.present[idx_q];
			out_q.string_offset  <= head.present[idx_q] ? head.offset[idx_q] : 16'd0;
			out_q.run_last       <= last;
		end
	end

endmodule

// ===== sv/smbios_table_string_locator_top.sv =====
// Top level of the SMBIOS structure-table string locator.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | request   | in_valid / in_stall      | in_data  (in_item_t)
//  out     | result    | out_valid / out_stall    | out_data (out_item_t)
//  cfg     | write     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One table byte is taken every cycle. A type 0 structure gives three results
// and a type 1 structure four, issued back to back from the output register
// unless out_stall holds them; the structure queue (QUEUE_DEPTH entries)
// absorbs them, and since every structure spans at least six bytes the input
// stalls only while the result side itself is stalled and the queue has filled.
// Reset clears the walk state and both config registers; no clearing pass.
// cfg_ready is always high.
module smbios_table_string_locator_top import sstl_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] table_length_q, structure_limit_q;
	run_push_t   push;
	run_t        head;
	logic        q_full, head_valid, pop;

	// config registers: to be written only while idle (the block does not enforce this), so no shadowing is needed
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q    <= '0;
			structure_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_LENGTH:    table_length_q    <= cfg_data;
				CFG_STRUCTURE_LIMIT: structure_limit_q <= cfg_data;
				default:             table_length_q    <= table_length_q;
			endcase
		end
	end

	// front: parse headers, skip the formatted area, scan the string set
	sstl_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.table_length    (table_length_q),
		.structure_limit (structure_limit_q),
		.queue_full      (q_full),
		.push            (push)
	);

	// hold closed structures until the emitter drains them
	sstl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back: issue one result per wanted string, advance on each take
	sstl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && q_full))
		else $error("structure pushed into a full queue");

	a_absent_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.string_present |-> out_data.string_offset == 16'd0)
		else $error("absent string carries an offset");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.run_last
		|-> out_data.string_slot == 3'd2 || out_data.string_slot == 3'd6)
		else $error("run closed on a wrong slot");

	a_pop_only_when_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
`endif

endmodule
